// ----- src/smes_pkg.sv -----
`default_nettype none

package smes_pkg;

    // Matrix geometry; the coordinate fields are fixed at six bits.
    localparam int COORD_W = 6;
    localparam int MAX_DIM = 2 ** COORD_W;
    localparam int SLOTS   = MAX_DIM * (MAX_DIM - 1) / 2;
    localparam int SLOT_AW = $clog2(SLOTS);

    localparam int WORD_W  = 32;
    localparam int HALF_W  = 16;
    localparam int COUNT_W = 11;
    localparam int DIM_W   = 7;

    typedef enum logic [1:0] {
        CMD_READ        = 2'd0,
        CMD_WRITE       = 2'd1,
        CMD_WRITE_HALVES = 2'd2,
        CMD_FIND        = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                command;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [WORD_W-1:0]   value_bits;
        logic [HALF_W-1:0]   high_half;
        logic [HALF_W-1:0]   low_half;
        logic [SLOT_AW-1:0]  start_index;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic                present;
        logic [COORD_W-1:0]  found_row;
        logic [COORD_W-1:0]  found_col;
        logic [SLOT_AW-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
        logic [DIM_W-1:0]    max_dim;
    } out_item_t;

    // Status of the packed-index to (row, col) splitter.
    typedef struct packed {
        logic                done;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
    } split_res_t;

    // First packed index of row r: r*(r-1)/2.
    function automatic logic [SLOT_AW-1:0] row_base(input logic [COORD_W-1:0] r);
        logic [2*COORD_W-1:0] prod;
        prod = (2*COORD_W)'(r) * ((2*COORD_W)'(r) - (2*COORD_W)'(1));
        if (r == '0) begin
            prod = '0;
        end
        return SLOT_AW'(prod >> 1);
    endfunction

    // Position of the lowest set bit; zero when none is set.
    function automatic logic [COORD_W-1:0] lowest_bit(input logic [MAX_DIM-1:0] v);
        logic [MAX_DIM-1:0] iso;
        logic [COORD_W-1:0] idx;
        iso = v & (~v + MAX_DIM'(1));
        idx = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            if (iso[i]) begin
                idx = idx | COORD_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- src/symmetric_matrix_entry_store_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   smes_pkg::in_item_t  (command, coordinates, data)
// m_        out        m_valid / m_ready   smes_pkg::out_item_t (word, found entry, counters)
//
// Read and write: the accept cycle reads the valid row and the word, the next
// writes the row back and registers the result; one transaction is in flight
// at a time.
// Find-next searches the row of the start index bit by bit, then reads the
// first row, scans one row of valid bits per cycle, and fetches the word:
// the address state, then the data state.
// After reset the valid-bit memory is cleared, one row a cycle, with s_ready
// low. A finished result waits in a hold stage while the output register is
// stalled; no new transaction is taken until it moves on.
module symmetric_matrix_entry_store_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  smes_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smes_pkg::out_item_t  m_item
);

    import smes_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR      = 9'b000000001,
        ST_IDLE       = 9'b000000010,
        ST_ACCESS     = 9'b000000100,
        ST_SPLIT      = 9'b000001000,
        ST_SCAN_RD    = 9'b000010000,
        ST_SCAN_CHK   = 9'b000100000,
        ST_FETCH_ADR  = 9'b001000000,
        ST_FETCH_DATA = 9'b010000000,
        ST_HOLD       = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] clr_reg, clr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DIM_W-1:0]   dim_reg, dim_next;
    logic               m_valid_reg, m_valid_next;

    in_item_t           item_reg, item_next;
    logic [COORD_W-1:0] r_reg, r_next;
    logic [COORD_W-1:0] c_reg, c_next;
    logic               ok_reg, ok_next;
    logic [SLOT_AW-1:0] slot_reg, slot_next;
    out_item_t          res_reg, res_next;
    out_item_t          m_item_reg, m_item_next;

    // memories
    logic               v_we;
    logic [COORD_W-1:0] v_waddr, v_raddr;
    logic [MAX_DIM-1:0] v_wdata, v_rdata;
    logic               w_we;
    logic [SLOT_AW-1:0] w_raddr;
    logic [WORD_W-1:0]  w_wdata, w_rdata;

    split_res_t         split_res;

    logic               accept;
    logic [COORD_W-1:0] in_r, in_c;
    logic               in_ok;
    logic [SLOT_AW-1:0] in_slot;
    logic               hit, is_wr, do_store;
    logic [DIM_W-1:0]   top_dim;
    logic [MAX_DIM-1:0] masked;
    logic               last_row;
    logic [SLOT_AW-1:0] fetch_slot;
    logic               out_free;
    logic               finish;
    out_item_t          result;

    smes_ram #(
        .WIDTH(MAX_DIM),
        .DEPTH(MAX_DIM)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    smes_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SLOTS)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (slot_reg),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    smes_index_split u_split (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && (s_item.command == CMD_FIND)),
        .index   (s_item.start_index),
        .res     (split_res)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Order the coordinates so the larger one is the row.
    assign in_r    = (s_item.row > s_item.col) ? s_item.row : s_item.col;
    assign in_c    = (s_item.row > s_item.col) ? s_item.col : s_item.row;
    assign in_ok   = (in_r != in_c) && ({1'b0, in_r} < DIM_W'(MAX_DIM));
    assign in_slot = row_base(in_r) + SLOT_AW'(in_c);

    assign hit      = v_rdata[c_reg];
    assign is_wr    = (item_reg.command == CMD_WRITE) ||
                      (item_reg.command == CMD_WRITE_HALVES);
    assign do_store = (state_reg == ST_ACCESS) && is_wr && ok_reg;
    assign w_wdata  = (item_reg.command == CMD_WRITE) ? item_reg.value_bits
                                                       : {item_reg.high_half, item_reg.low_half};
    assign top_dim  = DIM_W'(r_reg) + DIM_W'(1);

    // Scan: drop columns below the start column of the first row.
    assign masked     = v_rdata & ({MAX_DIM{1'b1}} << c_reg);
    assign last_row   = (r_reg == COORD_W'(MAX_DIM - 1));
    assign fetch_slot = row_base(r_reg) + SLOT_AW'(c_reg);

    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_reg;
        v_wdata = v_rdata | (MAX_DIM'(1) << c_reg);
        if (state_reg == ST_CLEAR) begin
            v_we    = 1'b1;
            v_waddr = clr_reg;
            v_wdata = '0;
        end else if (do_store) begin
            v_we = 1'b1;
        end
        w_we = do_store;
    end

    always_comb begin
        case (state_reg)
            ST_IDLE:     v_raddr = in_r;
            ST_SCAN_CHK: v_raddr = r_reg + COORD_W'(1);
            default:     v_raddr = r_reg;
        endcase
        case (state_reg)
            ST_IDLE:      w_raddr = in_slot;
            ST_FETCH_ADR: w_raddr = fetch_slot;
            default:      w_raddr = slot_reg;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        dim_next   = dim_reg;
        if (do_store) begin
            if (!hit) begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (top_dim > dim_reg) begin
                dim_next = top_dim;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        ok_next      = ok_reg;
        slot_next    = slot_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        finish       = 1'b0;

        result             = '0;
        result.entry_count = count_next;
        result.max_dim     = dim_next;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + COORD_W'(1);
                if (clr_reg == COORD_W'(MAX_DIM - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    item_next = s_item;
                    r_next    = in_r;
                    c_next    = in_c;
                    ok_next   = in_ok;
                    slot_next = in_slot;
                    state_next = (s_item.command == CMD_FIND) ? ST_SPLIT : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                finish = 1'b1;
                if (is_wr) begin
                    result.present = ok_reg;
                    result.word    = ok_reg ? w_wdata : '0;
                end else begin
                    result.present = ok_reg && hit;
                    result.word    = (ok_reg && hit) ? w_rdata : '0;
                end
            end
            ST_SPLIT: begin
                if (split_res.done) begin
                    if (item_reg.start_index >= SLOT_AW'(SLOTS)) begin
                        finish = 1'b1;
                    end else begin
                        r_next     = split_res.row;
                        c_next     = split_res.col;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                // next row is already being read, one row per cycle
                if (masked != '0) begin
                    c_next     = lowest_bit(masked);
                    state_next = ST_FETCH_ADR;
                end else if (last_row) begin
                    finish = 1'b1;
                end else begin
                    r_next = r_reg + COORD_W'(1);
                    c_next = '0;
                end
            end
            ST_FETCH_ADR: begin
                slot_next  = fetch_slot;
                state_next = ST_FETCH_DATA;
            end
            ST_FETCH_DATA: begin
                finish             = 1'b1;
                result.word        = w_rdata;
                result.present     = 1'b1;
                result.found_row   = r_reg;
                result.found_col   = c_reg;
                result.found_index = slot_reg;
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            if (out_free) begin
                m_item_next  = result;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end else begin
                res_next   = result;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            dim_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            dim_reg     <= dim_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        ok_reg     <= ok_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

// ----- src/smes_ram.sv -----
`default_nettype none

module smes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/smes_index_split.sv -----
`default_nettype none

// Splits a packed index into row and column: a bit-by-bit search for the
// largest row whose base index does not exceed the index, one bit a cycle.
module smes_index_split (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [smes_pkg::SLOT_AW-1:0]  index,
    output smes_pkg::split_res_t          res
);

    import smes_pkg::*;

    logic [COORD_W-1:0] probe_reg, probe_next;
    logic               done_reg, done_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [SLOT_AW-1:0] index_reg, index_next;

    logic [COORD_W-1:0] trial;
    logic               take;

    assign trial = row_reg | probe_reg;
    assign take  = row_base(trial) <= index_reg;

    always_comb begin
        probe_next = probe_reg;
        done_next  = 1'b0;
        row_next   = row_reg;
        index_next = index_reg;
        if (start) begin
            probe_next = {1'b1, {(COORD_W-1){1'b0}}};
            row_next   = '0;
            index_next = index;
        end else if (probe_reg != '0) begin
            if (take) begin
                row_next = trial;
            end
            probe_next = probe_reg >> 1;
            done_next  = probe_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            probe_reg <= probe_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        index_reg <= index_next;
    end

    assign res.done = done_reg;
    assign res.row  = row_reg;
    assign res.col  = COORD_W'(index_reg - row_base(row_reg));

endmodule

`default_nettype wire

// ----- src/smes_checker.sv -----
`default_nettype none

module smes_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input smes_pkg::in_item_t   s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input smes_pkg::out_item_t  m_item
);

    import smes_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // one transaction in flight: no acceptance right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    // absent answers carry no word and no location
    a_absent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.present |-> m_item.word == '0 &&
            m_item.found_row == '0 && m_item.found_col == '0 &&
            m_item.found_index == '0)
        else $error("absent result carries data");

    // found entry lies below the diagonal
    a_found_lower: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.found_row != '0 |-> m_item.found_col < m_item.found_row)
        else $error("found entry not below the diagonal");

    // any stored entry implies at least a 2x2 matrix
    a_dim_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.entry_count != '0 |-> m_item.max_dim >= DIM_W'(2))
        else $error("entry count and dimension disagree");

endmodule

bind symmetric_matrix_entry_store_unit smes_checker u_smes_checker (.*);

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smes_pkg::*;

    typedef struct {
        in_item_t  item;
        bit        known;
        out_item_t answer;
    } directed_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    // Shadow copy of the matrix store
    logic [WORD_W-1:0]  shadow_words [SLOTS];
    bit                 shadow_valid [SLOTS];
    logic [COUNT_W-1:0] shadow_count = '0;
    logic [DIM_W-1:0]   shadow_dim   = '0;

    out_item_t            expected_results [$];
    out_item_t            oldest_expected;
    logic [2*COORD_W-1:0] written_coords [$];
    directed_row_t        directed_rows [$];
    int                   errors     = 0;
    bit                   calm       = 1'b0;
    int                   ready_hold = 0;

    symmetric_matrix_entry_store_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL symmetric_matrix_entry_store_unit");
        $finish;
    end

    function automatic void add_row(input directed_row_t d);
        directed_rows.insert(directed_rows.size(), d);
    endfunction

    function automatic void note_pair(input logic [2*COORD_W-1:0] p);
        written_coords.insert(written_coords.size(), p);
    endfunction

    function automatic void expect_result(input out_item_t res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // Orders the coordinates; false on the diagonal.
    function automatic bit locate_slot(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                                       output int slot);
        int r;
        int c;
        r = (a > b) ? int'(a) : int'(b);
        c = (a > b) ? int'(b) : int'(a);
        slot = r * (r - 1) / 2 + c;
        return r != c;
    endfunction

    function automatic out_item_t predict_store_access(input in_item_t it);
        out_item_t         res;
        int                slot;
        int                r;
        logic [WORD_W-1:0] w;
        res = '0;
        case (it.command)
            CMD_READ: begin
                if (locate_slot(it.row, it.col, slot) && shadow_valid[slot]) begin
                    res.word    = shadow_words[slot];
                    res.present = 1'b1;
                end
            end
            CMD_WRITE, CMD_WRITE_HALVES: begin
                if (it.command == CMD_WRITE) begin
                    w = it.value_bits;
                end else begin
                    w = {it.high_half, it.low_half};
                end
                if (locate_slot(it.row, it.col, slot)) begin
                    if (!shadow_valid[slot]) begin
                        shadow_valid[slot] = 1'b1;
                        shadow_count       = shadow_count + COUNT_W'(1);
                    end
                    shadow_words[slot] = w;
                    r = ((it.row > it.col) ? int'(it.row) : int'(it.col)) + 1;
                    if (r > int'(shadow_dim)) begin
                        shadow_dim = DIM_W'(r);
                    end
                    res.word    = w;
                    res.present = 1'b1;
                end
            end
            default: begin
                for (int i = int'(it.start_index); i < SLOTS; i++) begin
                    if (shadow_valid[i]) begin
                        r = 1;
                        while (r * (r + 1) / 2 <= i) begin
                            r++;
                        end
                        res.word        = shadow_words[i];
                        res.present     = 1'b1;
                        res.found_row   = COORD_W'(r);
                        res.found_col   = COORD_W'(i - r * (r - 1) / 2);
                        res.found_index = SLOT_AW'(i);
                        break;
                    end
                end
            end
        endcase
        res.entry_count = shadow_count;
        res.max_dim     = shadow_dim;
        return res;
    endfunction

    // Mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // A coordinate pair written earlier, in either order.
    function automatic logic [2*COORD_W-1:0] stored_pair();
        logic [2*COORD_W-1:0] pair;
        pair = written_coords[$urandom_range(0, written_coords.size() - 1)];
        if ($urandom_range(0, 1) == 0) begin
            pair = {pair[COORD_W-1:0], pair[2*COORD_W-1:COORD_W]};
        end
        return pair;
    endfunction

    function automatic in_item_t random_item();
        in_item_t             it;
        int                   pick;
        int                   slot;
        logic [2*COORD_W-1:0] pair;
        it.command     = CMD_READ;
        it.row         = COORD_W'($urandom);
        it.col         = COORD_W'($urandom);
        it.value_bits  = $urandom;
        it.high_half   = HALF_W'($urandom);
        it.low_half    = HALF_W'($urandom);
        it.start_index = SLOT_AW'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            if (pick < 25) begin
                it.command = CMD_WRITE;
            end else begin
                it.command = CMD_WRITE_HALVES;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                it.col = it.row;
            end else if (pick < 30 && written_coords.size() != 0) begin
                {it.row, it.col} = stored_pair();
            end
            if (it.row != it.col) begin
                note_pair({it.row, it.col});
            end
        end else if (pick < 75) begin
            if ($urandom_range(0, 99) < 60 && written_coords.size() != 0) begin
                {it.row, it.col} = stored_pair();
            end
        end else begin
            it.command = CMD_FIND;
            pick = $urandom_range(0, 99);
            if (pick < 50 && written_coords.size() != 0) begin
                // land on or just ahead of a stored entry
                pair = stored_pair();
                void'(locate_slot(pair[2*COORD_W-1:COORD_W], pair[COORD_W-1:0], slot));
                slot = slot - int'($urandom_range(0, 3));
                if (slot < 0) begin
                    slot = 0;
                end
                it.start_index = SLOT_AW'(slot);
            end else if (pick < 85) begin
                it.start_index = SLOT_AW'($urandom_range(0, SLOTS - 1));
            end else begin
                it.start_index = SLOT_AW'($urandom_range(SLOTS, 2 ** SLOT_AW - 1));
            end
        end
        return it;
    endfunction

    function automatic directed_row_t step_row(input cmd_t cmd, input int row, input int col,
                                               input logic [WORD_W-1:0] value, input int high,
                                               input int low, input int start);
        directed_row_t d;
        d.item.command     = cmd;
        d.item.row         = COORD_W'(row);
        d.item.col         = COORD_W'(col);
        d.item.value_bits  = value;
        d.item.high_half   = HALF_W'(high);
        d.item.low_half    = HALF_W'(low);
        d.item.start_index = SLOT_AW'(start);
        d.known            = 1'b0;
        d.answer           = '0;
        return d;
    endfunction

    function automatic directed_row_t known(input directed_row_t d, input logic [WORD_W-1:0] word,
                                            input bit present, input int frow, input int fcol,
                                            input int fidx, input int count, input int dim);
        d.known              = 1'b1;
        d.answer.word        = word;
        d.answer.present     = present;
        d.answer.found_row   = COORD_W'(frow);
        d.answer.found_col   = COORD_W'(fcol);
        d.answer.found_index = SLOT_AW'(fidx);
        d.answer.entry_count = COUNT_W'(count);
        d.answer.max_dim     = DIM_W'(dim);
        return d;
    endfunction

    task automatic send_item(input in_item_t it, input bit is_known, input out_item_t answer);
        out_item_t predicted;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_store_access(it);
        expect_result(is_known ? answer : predicted);
    endtask

    task automatic sender_idle();
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (calm) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready) begin
            m_ready    <= 1'b0;
            ready_hold <= idle_len() - 1;
        end else begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $time, m_item);
                errors++;
            end else begin
                oldest_expected = expected_results.pop_front();
                check_field("word", oldest_expected.word, m_item.word);
                check_field("present", WORD_W'(oldest_expected.present), WORD_W'(m_item.present));
                check_field("found_row", WORD_W'(oldest_expected.found_row),
                            WORD_W'(m_item.found_row));
                check_field("found_col", WORD_W'(oldest_expected.found_col),
                            WORD_W'(m_item.found_col));
                check_field("found_index", WORD_W'(oldest_expected.found_index),
                            WORD_W'(m_item.found_index));
                check_field("entry_count", WORD_W'(oldest_expected.entry_count),
                            WORD_W'(m_item.entry_count));
                check_field("max_dim", WORD_W'(oldest_expected.max_dim), WORD_W'(m_item.max_dim));
            end
        end
    end

    initial begin
        add_row(known(step_row(CMD_READ, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
        add_row(known(step_row(CMD_FIND, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
        add_row(known(step_row(CMD_WRITE_HALVES, 0, 1, 0, 0, 0, 0),
                      0, 1, 0, 0, 0, 1, 2));
        // diagonal writes leave everything alone
        add_row(known(step_row(CMD_WRITE, 7, 7, 32'h0000_1234, 0, 0, 0),
                      0, 0, 0, 0, 0, 1, 2));
        add_row(known(step_row(CMD_WRITE_HALVES, 5, 3, 0, 16'hFFFF, 0, 0),
                      32'hFFFF_0000, 1, 0, 0, 0, 2, 6));
        // same slot, swapped order: replaces the word, count unchanged
        add_row(known(step_row(CMD_WRITE_HALVES, 3, 5, 0, 0, 16'hFFFF, 0),
                      32'h0000_FFFF, 1, 0, 0, 0, 2, 6));
        add_row(known(step_row(CMD_WRITE, 63, 62, 32'hFFFF_FFFF, 0, 0, 0),
                      32'hFFFF_FFFF, 1, 0, 0, 0, 3, 64));
        add_row(known(step_row(CMD_WRITE_HALVES, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0),
                      0, 0, 0, 0, 0, 3, 64));
        add_row(step_row(CMD_READ, 5, 3, 0, 0, 0, 0));
        add_row(known(step_row(CMD_READ, 62, 63, 0, 0, 0, 0),
                      32'hFFFF_FFFF, 1, 0, 0, 0, 3, 64));
        add_row(known(step_row(CMD_READ, 63, 63, 0, 0, 0, 0), 0, 0, 0, 0, 0, 3, 64));
        add_row(known(step_row(CMD_READ, 10, 2, 0, 0, 0, 0), 0, 0, 0, 0, 0, 3, 64));
        add_row(known(step_row(CMD_FIND, 0, 0, 0, 0, 0, 0), 0, 1, 1, 0, 0, 3, 64));
        add_row(step_row(CMD_FIND, 0, 0, 0, 0, 0, 1));
        add_row(known(step_row(CMD_FIND, 0, 0, 0, 0, 0, 2015),
                      32'hFFFF_FFFF, 1, 63, 62, 2015, 3, 64));
        // start past the last slot finds nothing
        add_row(known(step_row(CMD_FIND, 0, 0, 0, 0, 0, 2016),
                      0, 0, 0, 0, 0, 3, 64));
        add_row(known(step_row(CMD_FIND, 63, 63, 32'hFFFF_FFFF, 16'hFFFF,
                               16'hFFFF, 2047), 0, 0, 0, 0, 0, 3, 64));
        add_row(step_row(CMD_WRITE, 0, 63, 32'hAAAA_AAAA, 0, 0, 0));
        add_row(step_row(CMD_WRITE, 63, 0, 32'h5555_5555, 0, 0, 0));
        add_row(step_row(CMD_FIND, 0, 0, 0, 0, 0, 14));
        add_row(step_row(CMD_WRITE_HALVES, 33, 30, 0, 16'hA5A5, 16'h5A5A, 0));
        add_row(step_row(CMD_READ, 30, 33, 0, 0, 0, 0));
        add_row(step_row(CMD_READ, 1, 0, 0, 0, 0, 0));
        note_pair({6'd1, 6'd0});
        note_pair({6'd5, 6'd3});
        note_pair({6'd63, 6'd62});
        note_pair({6'd63, 6'd0});
        note_pair({6'd33, 6'd30});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            sender_idle();
            send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].answer);
        end
        drain();

        for (int n = 0; n < 950; n++) begin
            calm = (n >= 600 && n < 700);
            if (n == 450) begin
                drain();
            end else begin
                sender_idle();
            end
            send_item(random_item(), 1'b0, '0);
        end
        drain();
        repeat (100) @(posedge aclk);

        if (errors == 0) begin
            $display("PASS symmetric_matrix_entry_store_unit");
        end else begin
            $display("FAIL symmetric_matrix_entry_store_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
